### hw/rtl/bgfb_pkg.sv
package bgfb_pkg;

    // Command codes carried on the func field.
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_BOTTOM = 2'd1;
    localparam logic [1:0] FUNC_CENTER = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_REFRESH_ENABLE = 1'b0;
    localparam logic CFG_REFRESH_PERIOD = 1'b1;

    localparam logic [15:0] RESET_PERIOD = 16'd1600;

    // One frame is 8 pages times 2 halves; each half is 64 columns.
    localparam int HALF_COLS  = 64;
    localparam int FRAME_BITS = HALF_COLS * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAR,
        ST_SWEEP,
        ST_PACK,
        ST_LOAD
    } bgfb_state_t;

    typedef struct packed {
        logic accept;
        logic bar_write;
        logic sweep;
        logic load;
    } bgfb_cmd_t;

    typedef struct packed {
        logic col_ok;
        logic frame_due;
        logic sweep_done;
        logic frame_done;
        logic out_free;
    } bgfb_sts_t;

endpackage

### hw/rtl/bgfb_ctrl.sv
module bgfb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic [1:0]           func,
    input  bgfb_pkg::bgfb_sts_t  sts,
    output bgfb_pkg::bgfb_cmd_t  cmd,
    output logic                 cmd_stall,
    output bgfb_pkg::bgfb_state_t state
);
    import bgfb_pkg::*;

    bgfb_state_t state_reg;
    bgfb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall  = 1'b0;
                cmd.accept = cmd_valid;
                if (cmd_valid)
                begin
                    priority if (func == FUNC_TICK && sts.frame_due)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if ((func == FUNC_BOTTOM || func == FUNC_CENTER) && sts.col_ok)
                    begin
                        state_next = ST_BAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAR:
            begin
                cmd.bar_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done)
                begin
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.frame_done ? ST_IDLE : ST_SWEEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

### hw/rtl/bgfb_datapath.sv
module bgfb_datapath #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bgfb_pkg::bgfb_cmd_t              cmd,
    output bgfb_pkg::bgfb_sts_t              sts,
    input  logic [1:0]                       func,
    input  logic [6:0]                       column,
    input  logic [5:0]                       level,
    input  logic                             color,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             res_stall,
    output logic                             res_valid,
    output logic [2:0]                       page,
    output logic                             half,
    output logic [bgfb_pkg::FRAME_BITS-1:0]  bytes,
    output logic                             last
);
    import bgfb_pkg::*;

    localparam int          CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [7:0]  COL_LIMIT = 8'(COLUMNS);
    localparam logic [6:0]  HALF_ROW  = 7'(ROWS / 2);

    // Column store: one word per column, bit r is row r.
    logic [ROWS-1:0]    mem [COLUMNS];
    logic [COLUMNS-1:0] valid_reg;
    logic [ROWS-1:0]    rd_data_reg;
    logic               rd_ok_reg;

    logic               refresh_enable_reg;
    logic [15:0]        refresh_period_reg;
    logic [15:0]        tick_count_reg;

    logic [CW-1:0]      bar_addr_reg;
    logic [ROWS-1:0]    bar_mask_reg;
    logic               bar_color_reg;

    logic [5:0]         sweep_cnt_reg;
    logic               cap_reg;
    logic [3:0]         pos_reg;
    logic [FRAME_BITS-1:0] asm_reg;

    logic               out_valid_reg;
    logic [2:0]         out_page_reg;
    logic               out_half_reg;
    logic               out_last_reg;
    logic [FRAME_BITS-1:0] out_bytes_reg;

    logic [6:0]         rd_col;
    logic [CW-1:0]      rd_addr;
    logic               rd_in_range;
    logic [ROWS-1:0]    old_word;
    logic [ROWS-1:0]    new_word;
    logic [ROWS-1:0]    bar_mask;
    logic [63:0]        word64;
    logic [7:0]         page_slice;
    logic [7:0]         page_byte;
    logic [16:0]        tick_next;
    logic [16:0]        period;
    logic               tick_wrap;
    logic [6:0]         half_lvl;

    // Read address: the sweep column during a sweep, the incoming column otherwise.
    assign rd_col      = cmd.sweep ? {pos_reg[0], sweep_cnt_reg} : column;
    assign rd_addr     = rd_col[CW-1:0];
    assign rd_in_range = ({1'b0, rd_col} < COL_LIMIT);

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.bar_write)
        begin
            mem[bar_addr_reg] <= new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= rd_in_range && valid_reg[rd_addr];
        end
    end

    assign old_word = rd_ok_reg ? rd_data_reg : '0;
    assign new_word = bar_color_reg ? (old_word | bar_mask_reg) : (old_word & ~bar_mask_reg);

    // Rows covered by a bar, computed per row.
    assign half_lvl = {2'b00, level[5:1]};
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            if (func == FUNC_BOTTOM)
            begin
                bar_mask[r] = (7'(r) <= {1'b0, level});
            end
            else
            begin
                bar_mask[r] = (7'(r) <= HALF_ROW + half_lvl) && (7'(r) + half_lvl >= HALF_ROW);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bar_addr_reg  <= column[CW-1:0];
            bar_mask_reg  <= bar_mask;
            bar_color_reg <= color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.accept && func == FUNC_CLEAR)
        begin
            valid_reg <= '0;
        end
        else if (cmd.bar_write)
        begin
            valid_reg[bar_addr_reg] <= 1'b1;
        end
    end

    // Tick counter and configuration.
    assign period    = (refresh_period_reg == 16'd0) ? 17'h10000 : {1'b0, refresh_period_reg};
    assign tick_next = {1'b0, tick_count_reg} + 17'd1;
    assign tick_wrap = (tick_next >= period);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_enable_reg <= 1'b0;
            refresh_period_reg <= RESET_PERIOD;
            tick_count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_REFRESH_ENABLE: refresh_enable_reg <= cfg_data[0];
                    CFG_REFRESH_PERIOD: refresh_period_reg <= cfg_data;
                    default:            refresh_enable_reg <= refresh_enable_reg;
                endcase
            end
            if (cmd.accept && func == FUNC_TICK)
            begin
                tick_count_reg <= tick_wrap ? 16'd0 : tick_next[15:0];
            end
        end
    end

    // Page byte of the column read last cycle: bit k is row (7-page)*8+7-k.
    always_comb
    begin
        word64             = '0;
        word64[ROWS-1:0]   = old_word;
        page_slice         = word64[{~pos_reg[3:1], 3'b000} +: 8];
        for (int k = 0; k < 8; k++)
        begin
            page_byte[k] = page_slice[7-k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            cap_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg <= cmd.sweep;
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 6'd1;
            end
            if (cmd.accept && func == FUNC_TICK)
            begin
                pos_reg <= '0;
            end
            else if (cmd.load)
            begin
                pos_reg <= pos_reg + 4'd1;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_reg)
        begin
            asm_reg <= {page_byte, asm_reg[FRAME_BITS-1:8]};
        end
        if (cmd.load)
        begin
            out_bytes_reg <= asm_reg;
            out_page_reg  <= pos_reg[3:1];
            out_half_reg  <= pos_reg[0];
            out_last_reg  <= (pos_reg == 4'hF);
        end
    end

    assign sts.col_ok     = ({1'b0, column} < COL_LIMIT);
    assign sts.frame_due  = tick_wrap && refresh_enable_reg;
    assign sts.sweep_done = (sweep_cnt_reg == 6'(HALF_COLS - 1));
    assign sts.frame_done = (pos_reg == 4'hF);
    assign sts.out_free   = !out_valid_reg || !res_stall;

    assign res_valid = out_valid_reg;
    assign page      = out_page_reg;
    assign half      = out_half_reg;
    assign bytes     = out_bytes_reg;
    assign last      = out_last_reg;

endmodule

### hw/rtl/bar_graph_frame_buffer.sv
// Bar-graph frame buffer with page packing.
// The command channel (cmd_valid/cmd_stall) takes one item per handshake:
// a tick, a bottom bar, a centered bar or a clear of the whole pixel store.
// Bar items are a read-modify-write of one column word, read when taken and
// written back in ST_BAR; clears and ticks act when taken. The store is a
// single-port-write memory with a registered read, which sets the bar cost.
// A tick that completes the refresh period while refresh is enabled starts
// a frame: 16 result items on the result channel (res_valid/res_stall),
// page 0 to 7, half 0 before half 1, with last set on the final one.
// Each result is built by sweeping 64 columns through the memory read port,
// one column a cycle, and it waits to be loaded while the output register
// stays full. The command channel is stalled for the whole frame.
// The output register holds a finished item while the receiver stalls and
// the next one is assembled behind it; assembly waits only at the hand-off.
// At reset the store reads as all zero through per-column valid bits, so no
// clearing pass is needed; the tick counter is zero, refresh is disabled and
// the period is 1600. The user must write configuration through cfg_we,
// cfg_index and cfg_data while the block is idle; the block does not check.
module bar_graph_frame_buffer #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  func,
    input  logic [6:0]  column,
    input  logic [5:0]  level,
    input  logic        color,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  page,
    output logic        half,
    output logic [63:0] bytes_a,
    output logic [63:0] bytes_b,
    output logic [63:0] bytes_c,
    output logic [63:0] bytes_d,
    output logic [63:0] bytes_e,
    output logic [63:0] bytes_f,
    output logic [63:0] bytes_g,
    output logic [63:0] bytes_h,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import bgfb_pkg::*;

    bgfb_cmd_t             cmd;
    bgfb_sts_t             sts;
    bgfb_state_t           state;
    logic [FRAME_BITS-1:0] bytes;

    bgfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .func      (func),
        .sts       (sts),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .state     (state)
    );

    bgfb_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .func      (func),
        .column    (column),
        .level     (level),
        .color     (color),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .page      (page),
        .half      (half),
        .bytes     (bytes),
        .last      (last)
    );

    // Bytes of eight columns per field, lowest column in the lowest byte.
    assign bytes_a = bytes[63:0];
    assign bytes_b = bytes[127:64];
    assign bytes_c = bytes[191:128];
    assign bytes_d = bytes[255:192];
    assign bytes_e = bytes[319:256];
    assign bytes_f = bytes[383:320];
    assign bytes_g = bytes[447:384];
    assign bytes_h = bytes[511:448];

`ifndef SYNTHESIS
    // A frame-starting tick must lead straight into the column sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && func == FUNC_TICK && sts.frame_due) |=> (state == ST_SWEEP))
        else $error("frame tick did not start a sweep");

    // The last flag only ever marks page 7, half 1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && last) |-> (page == 3'd7 && half == 1'b1))
        else $error("last set on a result other than page 7 half 1");

    // A column write follows only an accepted bar item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_BAR) |-> $past(cmd.accept))
        else $error("bar write without an accepted item");
`endif

endmodule

### verif/bar_graph_frame_buffer_checker.sv
`timescale 1ns / 1ps

module bar_graph_frame_buffer_checker #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic [1:0]  func,
    input  logic [6:0]  column,
    input  logic [5:0]  level,
    input  logic        color,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [2:0]  page,
    input  logic        half,
    input  logic [63:0] bytes_a,
    input  logic [63:0] bytes_b,
    input  logic [63:0] bytes_c,
    input  logic [63:0] bytes_d,
    input  logic [63:0] bytes_e,
    input  logic [63:0] bytes_f,
    input  logic [63:0] bytes_g,
    input  logic [63:0] bytes_h,
    input  logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int unsigned slices_pending,
    output int unsigned mismatch_count
);
    import bgfb_pkg::*;

    // Only the first mismatches are printed; all of them are counted.
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [2:0]       page;
        logic             half;
        logic [7:0][63:0] lanes;
        logic             last;
    } frame_slice_t;

    logic [63:0]  pixel_cols [COLUMNS];
    logic [15:0]  tick_count;
    logic         refresh_on;
    logic [15:0]  refresh_period;
    frame_slice_t slice_q [$];

    string lane_names [8] = '{"bytes_a", "bytes_b", "bytes_c", "bytes_d",
                              "bytes_e", "bytes_f", "bytes_g", "bytes_h"};

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    task automatic clear_store();
        for (int c = 0; c < COLUMNS; c++)
        begin
            pixel_cols[c] = '0;
        end
    endtask

    task automatic draw_bar(input logic [6:0] col, input logic [5:0] lvl, input logic on,
                            input logic centered);
        int top;
        int h;
        if (int'(col) >= COLUMNS)
        begin
            return;
        end
        if (!centered)
        begin
            top = (int'(lvl) > ROWS - 1) ? ROWS - 1 : int'(lvl);
            for (int i = 0; i <= top; i++)
            begin
                pixel_cols[col][i] = on;
            end
        end
        else
        begin
            // Rows fan out from the middle row, one step every second level.
            for (int i = 0; i <= int'(lvl); i++)
            begin
                h = i / 2;
                if (ROWS / 2 + h < ROWS)
                begin
                    pixel_cols[col][ROWS / 2 + h] = on;
                end
                if (h <= ROWS / 2)
                begin
                    pixel_cols[col][ROWS / 2 - h] = on;
                end
            end
        end
    endtask

    function automatic logic [7:0] page_byte(input int col, input int pg);
        logic [7:0] b;
        int row;
        b = '0;
        if (col >= COLUMNS)
        begin
            return b;
        end
        for (int k = 0; k < 8; k++)
        begin
            row = (7 - pg) * 8 + 7 - k;
            if (row < ROWS)
            begin
                b[k] = pixel_cols[col][row];
            end
        end
        return b;
    endfunction

    function automatic frame_slice_t slice_of(input int pg, input int hf);
        frame_slice_t s;
        s.page = 3'(pg);
        s.half = 1'(hf);
        s.last = (pg == 7 && hf == 1);
        for (int w = 0; w < 8; w++)
        begin
            for (int c = 0; c < 8; c++)
            begin
                s.lanes[w][8 * c +: 8] = page_byte(hf * HALF_COLS + w * 8 + c, pg);
            end
        end
        return s;
    endfunction

    // A period of zero behaves as a full 16-bit wrap.
    task automatic advance_tick();
        int span;
        int nxt;
        span = (refresh_period == '0) ? 65536 : int'(refresh_period);
        nxt = int'(tick_count) + 1;
        if (nxt >= span)
        begin
            tick_count = '0;
            if (refresh_on)
            begin
                for (int pg = 0; pg < 8; pg++)
                begin
                    for (int hf = 0; hf < 2; hf++)
                    begin
                        slice_q.push_back(slice_of(pg, hf));
                    end
                end
            end
        end
        else
        begin
            tick_count = nxt[15:0];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        frame_slice_t want;
        logic [7:0][63:0] got_lanes;
        if (!rst_n)
        begin
            clear_store();
            tick_count     = '0;
            refresh_on     = 1'b0;
            refresh_period = RESET_PERIOD;
            slice_q.delete();
            mismatch_count = 0;
            slices_pending <= 0;
        end
        else
        begin
            // Results first: no result can stem from an item taken at the same edge.
            if (res_valid && !res_stall)
            begin
                if (slice_q.size() == 0)
                begin
                    report_mismatch("result with no frame pending", 64'({page, half}), '0);
                end
                else
                begin
                    want = slice_q.pop_front();
                    got_lanes = {bytes_h, bytes_g, bytes_f, bytes_e,
                                 bytes_d, bytes_c, bytes_b, bytes_a};
                    if (page !== want.page)
                    begin
                        report_mismatch("page", 64'(page), 64'(want.page));
                    end
                    if (half !== want.half)
                    begin
                        report_mismatch("half", 64'(half), 64'(want.half));
                    end
                    for (int w = 0; w < 8; w++)
                    begin
                        if (got_lanes[w] !== want.lanes[w])
                        begin
                            report_mismatch(lane_names[w], got_lanes[w], want.lanes[w]);
                        end
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch("last", 64'(last), 64'(want.last));
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_REFRESH_ENABLE)
                begin
                    refresh_on = cfg_data[0];
                end
                else
                begin
                    refresh_period = cfg_data;
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                case (func)
                    FUNC_TICK:   advance_tick();
                    FUNC_BOTTOM: draw_bar(column, level, color, 1'b0);
                    FUNC_CENTER: draw_bar(column, level, color, 1'b1);
                    FUNC_CLEAR:  clear_store();
                    default:     ;
                endcase
            end
            slices_pending <= slice_q.size();
        end
    end

endmodule

### verif/tb_bar_graph_frame_buffer.sv
`timescale 1ns / 1ps

module tb_bar_graph_frame_buffer;
    import bgfb_pkg::*;

    // After the last expected result, a bar or clear item may still be in
    // flight; this many cycles covers it comfortably before a register write.
    localparam int SETTLE_CYCLES  = 200;
    // The closing wait lasts a little longer than one unstalled frame.
    localparam int END_CYCLES     = 1200;
    // The longest quiet spell in a correct run is the closing wait; the
    // watchdog limit is several times that.
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  func;
    logic [6:0]  column;
    logic [5:0]  level;
    logic        color;
    logic        res_valid;
    logic        res_stall;
    logic [2:0]  page;
    logic        half;
    logic [63:0] bytes_a;
    logic [63:0] bytes_b;
    logic [63:0] bytes_c;
    logic [63:0] bytes_d;
    logic [63:0] bytes_e;
    logic [63:0] bytes_f;
    logic [63:0] bytes_g;
    logic [63:0] bytes_h;
    logic        last;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int unsigned slices_pending;
    int unsigned mismatch_count;

    // Items left in the current run of back-to-back commands with no gap.
    int unsigned burst_left;

    bar_graph_frame_buffer dut (.*);

    // The checker sits beside the block, predicts every frame slice from the
    // command stream and the register writes, and compares what comes out.
    bar_graph_frame_buffer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result side stalls at random: mostly short spells, now and then a
    // long one, and sometimes a long stretch with no stall at all so that
    // the block runs at full speed.
    initial
    begin : result_backpressure
        int unsigned span;
        res_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    res_stall <= 1'b0;
                    span = $urandom_range(40, 300);
                end
                2:
                begin
                    res_stall <= 1'b1;
                    span = $urandom_range(20, 60);
                end
                default:
                begin
                    res_stall <= 1'($urandom_range(0, 1));
                    span = $urandom_range(1, 3);
                end
            endcase
            repeat (span) @(posedge clk);
        end
    end

    // The watchdog counts cycles in which neither channel moves an item.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("bar_graph_frame_buffer verification failed");
        $finish;
    end

    // Picks the idle time in front of the next command item. Most items go
    // out at once or after a short gap; a few wait long; occasionally a burst
    // of items goes out with no gap at all.
    task automatic next_gap(output int unsigned gap);
        gap = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:       burst_left = $urandom_range(20, 40);
                1:       gap = $urandom_range(10, 40);
                2, 3, 4, 5, 6, 7, 8:
                         gap = $urandom_range(1, 3);
                default: gap = 0;
            endcase
        end
    endtask

    // Presents one command item and returns at the edge that accepts it.
    // The payload stays put while the block stalls.
    task automatic send_command(input logic [1:0] f, input logic [6:0] col,
                                input logic [5:0] lvl, input logic on);
        int unsigned gap;
        next_gap(gap);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        func      <= f;
        column    <= col;
        level     <= lvl;
        color     <= on;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted frame slice has come out.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (slices_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the block idle: no frame outstanding and
    // enough time for a trailing bar or clear item to finish.
    task automatic set_refresh(input logic enable, input logic [15:0] period);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_REFRESH_ENABLE, {15'd0, enable});
        write_register(CFG_REFRESH_PERIOD, period);
    endtask

    // One random item. Ticks come at the given percentage, clears rarely,
    // and the rest are bars of both kinds. Fields that a command ignores
    // still carry random values. Levels lean toward the two extremes and
    // most bars light pixels so that frames carry a real picture.
    task automatic random_command(input int unsigned tick_percent);
        int unsigned pick;
        logic [1:0] f;
        logic [5:0] lvl;
        pick = $urandom_range(0, 99);
        if (pick < tick_percent)
        begin
            f = FUNC_TICK;
        end
        else if (pick < tick_percent + 5)
        begin
            f = FUNC_CLEAR;
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            f = FUNC_BOTTOM;
        end
        else
        begin
            f = FUNC_CENTER;
        end
        case ($urandom_range(0, 5))
            0:       lvl = 6'd0;
            1:       lvl = 6'd63;
            default: lvl = 6'($urandom_range(0, 63));
        endcase
        send_command(f, 7'($urandom_range(0, 127)), lvl, ($urandom_range(0, 3) != 0));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        func       = FUNC_TICK;
        column     = '0;
        level      = '0;
        color      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_REFRESH_ENABLE;
        cfg_data   = '0;
        burst_left = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With the reset settings (refresh off, period 1600)
        // draw bars at the edge columns and levels: full and single-row
        // bottom bars, centered bars at level 0, 1, 62 and 63, where row 0
        // stays out of reach, and darkening over lit pixels.
        send_command(FUNC_BOTTOM, 7'd0,   6'd63, 1'b1);
        send_command(FUNC_BOTTOM, 7'd127, 6'd0,  1'b1);
        send_command(FUNC_CENTER, 7'd64,  6'd63, 1'b1);
        send_command(FUNC_CENTER, 7'd63,  6'd0,  1'b1);
        send_command(FUNC_CENTER, 7'd2,   6'd1,  1'b1);
        send_command(FUNC_CENTER, 7'd65,  6'd62, 1'b1);
        send_command(FUNC_BOTTOM, 7'd10,  6'd40, 1'b1);
        send_command(FUNC_BOTTOM, 7'd10,  6'd15, 1'b0);
        send_command(FUNC_CENTER, 7'd10,  6'd20, 1'b0);
        // Counts while refresh is off, but yields no frame.
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);

        // Period 1: every tick completes the period and dumps a frame.
        set_refresh(1'b1, 16'd1);
        send_command(FUNC_TICK,   7'd127, 6'd63, 1'b1);
        send_command(FUNC_CLEAR,  7'd5,   6'd5,  1'b1);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);
        send_command(FUNC_BOTTOM, 7'd127, 6'd63, 1'b1);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);

        // Period reached with refresh off: the count restarts silently.
        set_refresh(1'b0, 16'd1);
        send_command(FUNC_TICK,   7'd1,   6'd1,  1'b1);

        // A zero period stands for a full wrap, so these ticks only count.
        set_refresh(1'b1, 16'd0);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);

        set_refresh(1'b1, 16'd65535);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);

        // Lowering the period below the running count fires on the next tick.
        set_refresh(1'b1, 16'd2);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);
        send_command(FUNC_TICK,   7'd0,   6'd0,  1'b0);

        // Random part, in phases with different refresh settings. Halfway
        // through the first one the sender waits for the frames to drain.
        set_refresh(1'b1, 16'd3);
        repeat (20) random_command(20);
        drain_results();
        repeat (20) random_command(20);

        set_refresh(1'b0, 16'd1);
        repeat (30) random_command(30);

        set_refresh(1'b1, 16'd1);
        repeat (40) random_command(12);

        set_refresh(1'b1, 16'd7);
        repeat (28) random_command(30);

        drain_results();
        repeat (END_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && slices_pending == 0)
        begin
            $display("bar_graph_frame_buffer verification clean");
        end
        else
        begin
            $display("bar_graph_frame_buffer verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bgfb_pkg.sv
hw/rtl/bgfb_ctrl.sv
hw/rtl/bgfb_datapath.sv
hw/rtl/bar_graph_frame_buffer.sv
verif/bar_graph_frame_buffer_checker.sv
verif/tb_bar_graph_frame_buffer.sv
